### rtl/slbp_pkg.sv
`default_nettype none

package slbp_pkg;

	// Default carrier period and number of breathing steps.
	localparam int PwmPeriodMsDefault = 10;
	localparam int BrightStepsDefault = 10;

	// Register widths and reset values.
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 8;
	localparam int BlinkW    = 8;
	localparam int DimW      = 4;
	localparam int HoldW     = 8;
	localparam int MsW       = 9;
	localparam int LevelW    = 4;
	localparam int LevelCnt  = 16;

	localparam logic [BlinkW-1:0] BlinkHalfReset = 8'd100;
	localparam logic [DimW-1:0]   DimOnReset     = 4'd3;
	localparam logic [HoldW-1:0]  HoldReset      = 8'd15;

	// Register indexes on the configuration port.
	localparam logic [CfgIdxW-1:0] CfgBlinkHalf = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgDimOn     = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgHold      = 2'd2;

	// Pattern iteration in progress.
	typedef enum logic [3:0] {
		MODE_NONE   = 4'b0001,
		MODE_ERROR  = 4'b0010,
		MODE_CONN   = 4'b0100,
		MODE_BREATH = 4'b1000
	} mode_t;

endpackage

`default_nettype wire

### rtl/status_led_breathing_pwm.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// in        sink       in_valid/in_stall  error_event, link_connected
// out       source     out_valid/out_stall led_on
// cfg       sink       cfg_we             cfg_index, cfg_data
//
// Each tick beat is handled combinationally: mode choice, LED level and counter
// updates sit between the state registers and the led_on output register.
// One beat is taken per clock; in_stall rises only while a result waits in the
// output register and out_stall is high.
// Reset loads the default register values, clears the breathing level to 0 and starts with no pattern chosen.
module status_led_breathing_pwm
	import slbp_pkg::*;
#(
	parameter int PWM_PERIOD_MS = PwmPeriodMsDefault,
	parameter int BRIGHT_STEPS  = BrightStepsDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                error_event,
	input  wire logic                link_connected,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     led_on,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	localparam logic [MsW-1:0]    PeriodMs  = MsW'(PWM_PERIOD_MS);
	localparam logic [LevelW-1:0] StepsTop  = LevelW'(BRIGHT_STEPS);

	// On-time per breathing level, worked out at elaboration.
	logic [MsW-1:0] on_tab [LevelCnt];
	for (genvar g = 0; g < LevelCnt; g++) begin : g_on_tab
		localparam int OnMs = (g * PWM_PERIOD_MS) / BRIGHT_STEPS;
		assign on_tab[g] = MsW'(OnMs);
	end

	logic [BlinkW-1:0] blink_half_q;
	logic [DimW-1:0]   dim_on_q;
	logic [HoldW-1:0]  hold_q;

	logic              error_latched_q;
	logic              came_conn_q;
	logic [LevelW-1:0] level_q;
	logic              going_up_q;
	mode_t             mode_q;
	logic [MsW-1:0]    ms_q;
	logic [HoldW-1:0]  held_q;

	logic              error_latched_d;
	logic              came_conn_d;
	logic [LevelW-1:0] level_d;
	logic              going_up_d;
	mode_t             mode_d;
	logic [MsW-1:0]    ms_d;
	logic [HoldW-1:0]  held_d;
	logic              lit;

	logic              accept;
	logic [BlinkW-1:0] half;
	logic [MsW-1:0]    dim_on;
	logic [HoldW-1:0]  hold;
	logic [MsW-1:0]    ms_cur;
	logic [MsW-1:0]    ms_inc;
	logic [HoldW-1:0]  held_inc;

	// A new beat may enter unless a finished result is still held back.
	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	// Configuration registers; an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_half_q <= BlinkHalfReset;
			dim_on_q     <= DimOnReset;
			hold_q       <= HoldReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgBlinkHalf: blink_half_q <= cfg_data;
				CfgDimOn:     dim_on_q     <= cfg_data[DimW-1:0];
				CfgHold:      hold_q       <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Register values with their zero and saturation rules applied.
	assign half   = (blink_half_q == '0) ? BlinkW'(1) : blink_half_q;
	assign hold   = (hold_q == '0) ? HoldW'(1) : hold_q;
	assign dim_on = ({{(MsW-DimW){1'b0}}, dim_on_q} > PeriodMs) ? PeriodMs
		: {{(MsW-DimW){1'b0}}, dim_on_q};

	// Next state and LED level for one tick.
	always_comb begin
		error_latched_d = error_latched_q || error_event;
		came_conn_d     = came_conn_q;
		level_d         = level_q;
		going_up_d      = going_up_q;
		mode_d          = mode_q;
		ms_cur          = ms_q;
		held_d          = held_q;
		lit             = 1'b0;

		// Choose a pattern at the start of an iteration.
		if (mode_q == MODE_NONE) begin
			ms_cur = '0;
			held_d = '0;
			if (error_latched_d) begin
				mode_d = MODE_ERROR;
			end else if (link_connected) begin
				mode_d      = MODE_CONN;
				came_conn_d = 1'b1;
			end else begin
				if (came_conn_q) begin
					level_d     = '0;
					going_up_d  = 1'b1;
					came_conn_d = 1'b0;
				end
				mode_d = MODE_BREATH;
			end
		end

		ms_inc   = ms_cur + MsW'(1);
		ms_d     = ms_inc;
		held_inc = held_d + HoldW'(1);

		unique case (mode_d)
			MODE_ERROR: begin
				lit = ms_cur < {1'b0, half};
				if (ms_inc >= {half, 1'b0} || ms_inc == '0) begin
					mode_d = MODE_NONE;
				end
			end
			MODE_CONN: begin
				lit = ms_cur < dim_on;
				if (ms_inc >= PeriodMs) begin
					mode_d = MODE_NONE;
				end
			end
			MODE_BREATH: begin
				lit = ms_cur < on_tab[level_d];
				if (ms_inc >= PeriodMs) begin
					ms_d   = '0;
					held_d = held_inc;
					if (held_inc >= hold || held_inc == '0) begin
						held_d = '0;
						mode_d = MODE_NONE;
						// Step the triangle wave.
						if (going_up_d) begin
							level_d = level_d + LevelW'(1);
							if (level_d >= StepsTop) begin
								going_up_d = 1'b0;
							end
						end else begin
							if (level_d != '0) begin
								level_d = level_d - LevelW'(1);
							end
							if (level_d == '0) begin
								going_up_d = 1'b1;
							end
						end
					end
				end
			end
			default: begin
				lit = 1'b0;
			end
		endcase
	end

	// Pattern state advances on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_latched_q <= 1'b0;
			came_conn_q     <= 1'b0;
			level_q         <= '0;
			going_up_q      <= 1'b1;
			mode_q          <= MODE_NONE;
			ms_q            <= '0;
			held_q          <= '0;
		end else if (accept) begin
			error_latched_q <= error_latched_d;
			came_conn_q     <= came_conn_d;
			level_q         <= level_d;
			going_up_q      <= going_up_d;
			mode_q          <= mode_d;
			ms_q            <= ms_d;
			held_q          <= held_d;
		end
	end

	// Output register: holds a result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			led_on <= lit;
		end
	end

endmodule

`default_nettype wire
